// ===== rtl/smbus_rw_pkg.sv =====
package smbus_rw_pkg;

    localparam int unsigned QBT_W   = 16;
    localparam int unsigned ATT_W   = 8;
    localparam int unsigned ADDR_W  = 7;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned BCNT_W  = 4;
    localparam int unsigned QIDX_W  = 2;
    localparam int unsigned APB_AW  = 3;
    localparam int unsigned APB_DW  = 32;

    localparam logic [QBT_W-1:0]  QBT_RESET      = 16'd5;
    localparam logic [ATT_W-1:0]  ATTEMPTS_RESET = 8'd255;
    localparam logic [BYTE_W-1:0] CRC_POLY       = 8'h07;

    // Register indexes; the byte address is four times the index.
    localparam logic REG_QUARTER_BIT_TICKS = 1'b0;
    localparam logic REG_MAX_ATTEMPTS      = 1'b1;

    typedef enum logic [4:0] {
        PH_IDLE       = 5'd0,
        PH_START      = 5'd1,
        PH_ADDR_W     = 5'd2,
        PH_ACK_ADDR_W = 5'd3,
        PH_CMD        = 5'd4,
        PH_ACK_CMD    = 5'd5,
        PH_RSTART     = 5'd6,
        PH_ADDR_R     = 5'd7,
        PH_ACK_ADDR_R = 5'd8,
        PH_RX_LOW     = 5'd9,
        PH_MACK_LOW   = 5'd10,
        PH_RX_HIGH    = 5'd11,
        PH_MACK_HIGH  = 5'd12,
        PH_RX_PEC     = 5'd13,
        PH_MNACK_PEC  = 5'd14,
        PH_STOP_END   = 5'd15,
        PH_STOP_NACK  = 5'd16
    } t_phase;

    // One byte into the SMBus PEC (CRC-8, x^8+x^2+x+1), MSB first.
    function automatic logic [BYTE_W-1:0] crc8_feed(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[BYTE_W-1]) begin
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/smbus_read_word_pec_master.sv =====
// SMBus master for one Read Word with PEC, driving open-drain SCL and SDA.
// Input channel (i_valid / o_stall): every transfer is one time tick. With
// i_action high while idle it starts a transaction and latches the slave
// address and command; otherwise it just advances the bus sequencer, and
// i_sda_sample gives the SDA level seen during that tick.
// Output channel (o_valid / i_stall): exactly one result per input transfer,
// carrying the line levels for that tick, busy, and on the finishing tick
// done with either the read word or the failed flag.
// The result of an accepted tick is registered and shows in the cycle after
// the tick is taken. One tick is accepted every cycle as long as the result
// register is empty or being drained in the same cycle; the sequencer makes
// one small step per tick, so that single register stage sets the rate.
// When the receiver stalls, the result register holds and o_stall rises,
// so no tick is taken until the waiting result leaves.
// The APB port sets quarter_bit_ticks (address 0) and max_attempts
// (address 4); write them only while the block is idle.
// Reset (synchronous, active low) returns the sequencer to idle, empties
// the result register and loads the register defaults (5 and 255).
module smbus_read_word_pec_master
    import smbus_rw_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_action,
    input  logic [ADDR_W-1:0]   i_slave_address,
    input  logic [BYTE_W-1:0]   i_command,
    input  logic                i_sda_sample,

    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_scl_release,
    output logic                o_sda_release,
    output logic                o_busy_res,
    output logic                o_done_res,
    output logic [WORD_W-1:0]   o_read_word,
    output logic                o_failed,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    // Configuration registers.
    logic [QBT_W-1:0]  r_qbt;
    logic [ATT_W-1:0]  r_max_att;

    // Sequencer state.
    t_phase            r_phase,    n_phase;
    logic [BCNT_W-1:0] r_bit_cnt,  n_bit_cnt;
    logic [QIDX_W-1:0] r_qidx,     n_qidx;
    logic [QBT_W-1:0]  r_tick,     n_tick;
    logic [BYTE_W-1:0] r_shift,    n_shift;
    logic [BYTE_W-1:0] r_crc,      n_crc;
    logic [ATT_W-1:0]  r_att,      n_att;
    logic [ADDR_W-1:0] r_addr,     n_addr;
    logic [BYTE_W-1:0] r_cmd,      n_cmd;
    logic [BYTE_W-1:0] r_low,      n_low;
    logic [BYTE_W-1:0] r_high,     n_high;

    // Result register.
    logic              r_out_valid;
    logic              r_scl, r_sda, r_busy, r_done, r_fail;
    logic [WORD_W-1:0] r_word;

    logic              res_scl, res_sda, res_busy, res_done, res_fail;
    logic [WORD_W-1:0] res_word;

    logic              in_accept;
    logic              cfg_write;
    logic [QBT_W-1:0]  quarter_len;
    logic [ATT_W-1:0]  att_limit;
    logic              last_tick;
    logic [BCNT_W-1:0] bit_cnt_inc;
    logic [BYTE_W-1:0] send_val;
    logic [BYTE_W-1:0] byte_val;
    logic              is_send, is_rx_byte, is_rx_slot;
    logic              retry_exhausted;

    assign o_stall   = r_out_valid & i_stall;
    assign in_accept = i_valid & ~o_stall;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign prdata    = (paddr[2] == REG_MAX_ATTEMPTS) ?
                       {{(APB_DW-ATT_W){1'b0}}, r_max_att} :
                       {{(APB_DW-QBT_W){1'b0}}, r_qbt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qbt     <= QBT_RESET;
            r_max_att <= ATTEMPTS_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == REG_MAX_ATTEMPTS) begin
                r_max_att <= pwdata[ATT_W-1:0];
            end else begin
                r_qbt <= pwdata[QBT_W-1:0];
            end
        end
    end

    // A zero setting behaves like one.
    assign quarter_len = (r_qbt == '0) ? QBT_W'(1) : r_qbt;
    assign att_limit   = (r_max_att == '0) ? ATT_W'(1) : r_max_att;

    assign last_tick       = ({1'b0, r_tick} + (QBT_W+1)'(1)) >= {1'b0, quarter_len};
    assign bit_cnt_inc     = r_bit_cnt + BCNT_W'(1);
    assign retry_exhausted = r_att >= att_limit;

    assign is_send    = (r_phase == PH_ADDR_W) || (r_phase == PH_CMD) ||
                        (r_phase == PH_ADDR_R);
    assign is_rx_byte = (r_phase == PH_RX_LOW) || (r_phase == PH_RX_HIGH) ||
                        (r_phase == PH_RX_PEC);
    assign is_rx_slot = is_rx_byte || (r_phase == PH_ACK_ADDR_W) ||
                        (r_phase == PH_ACK_CMD) || (r_phase == PH_ACK_ADDR_R);

    always_comb begin
        unique case (r_phase)
            PH_ADDR_W: send_val = {r_addr, 1'b0};
            PH_CMD:    send_val = r_cmd;
            default:   send_val = {r_addr, 1'b1};
        endcase
    end

    assign byte_val = is_send ? send_val : r_shift;

    always_comb begin
        n_phase   = r_phase;
        n_bit_cnt = r_bit_cnt;
        n_qidx    = r_qidx;
        n_tick    = r_tick;
        n_shift   = r_shift;
        n_crc     = r_crc;
        n_att     = r_att;
        n_addr    = r_addr;
        n_cmd     = r_cmd;
        n_low     = r_low;
        n_high    = r_high;
        res_scl   = 1'b1;
        res_sda   = 1'b1;
        res_busy  = 1'b0;
        res_done  = 1'b0;
        res_word  = '0;
        res_fail  = 1'b0;

        if (r_phase == PH_IDLE) begin
            if (i_action) begin
                n_addr    = i_slave_address;
                n_cmd     = i_command;
                n_att     = ATT_W'(1);
                n_phase   = PH_START;
                n_bit_cnt = '0;
                n_qidx    = '0;
                n_tick    = '0;
                n_crc     = '0;
                n_shift   = '0;
                res_busy  = 1'b1;
            end
        end else begin
            res_busy = 1'b1;
            res_scl  = (r_qidx == 2'd1) || (r_qidx == 2'd2);
            if ((r_phase == PH_START) || (r_phase == PH_RSTART)) begin
                res_sda = (r_qidx < 2'd2);
            end else if ((r_phase == PH_STOP_END) || (r_phase == PH_STOP_NACK)) begin
                res_sda = (r_qidx >= 2'd2);
                res_scl = (r_qidx != 2'd0);
            end else if (is_send) begin
                res_sda = send_val[~r_bit_cnt[2:0]];
            end else if ((r_phase == PH_MACK_LOW) || (r_phase == PH_MACK_HIGH)) begin
                res_sda = 1'b0;
            end

            if (is_rx_slot && (r_qidx == 2'd2) && last_tick) begin
                n_shift = {r_shift[BYTE_W-2:0], i_sda_sample};
            end

            if (!last_tick) begin
                n_tick = r_tick + QBT_W'(1);
            end else begin
                n_tick = '0;
                if (r_qidx != 2'd3) begin
                    n_qidx = r_qidx + QIDX_W'(1);
                end else begin
                    // End of a bit slot: the sequencer moves on.
                    n_qidx = '0;
                    unique case (r_phase)
                        PH_START: begin
                            n_crc     = '0;
                            n_bit_cnt = '0;
                            n_phase   = PH_ADDR_W;
                        end
                        PH_RSTART: begin
                            n_bit_cnt = '0;
                            n_phase   = PH_ADDR_R;
                        end
                        PH_ADDR_W, PH_CMD, PH_ADDR_R,
                        PH_RX_LOW, PH_RX_HIGH, PH_RX_PEC: begin
                            n_bit_cnt = bit_cnt_inc;
                            if (bit_cnt_inc >= BCNT_W'(8)) begin
                                n_bit_cnt = '0;
                                if (r_phase == PH_RX_LOW) begin
                                    n_low = byte_val;
                                end
                                if (r_phase == PH_RX_HIGH) begin
                                    n_high = byte_val;
                                end
                                if (r_phase != PH_RX_PEC) begin
                                    n_crc = crc8_feed(r_crc, byte_val);
                                end
                                unique case (r_phase)
                                    PH_ADDR_W:  n_phase = PH_ACK_ADDR_W;
                                    PH_CMD:     n_phase = PH_ACK_CMD;
                                    PH_ADDR_R:  n_phase = PH_ACK_ADDR_R;
                                    PH_RX_LOW:  n_phase = PH_MACK_LOW;
                                    PH_RX_HIGH: n_phase = PH_MACK_HIGH;
                                    default:    n_phase = PH_MNACK_PEC;
                                endcase
                            end
                        end
                        PH_ACK_ADDR_W, PH_ACK_CMD, PH_ACK_ADDR_R: begin
                            if (r_shift[0]) begin
                                n_phase = PH_STOP_NACK;
                            end else begin
                                unique case (r_phase)
                                    PH_ACK_ADDR_W: n_phase = PH_CMD;
                                    PH_ACK_CMD:    n_phase = PH_RSTART;
                                    default:       n_phase = PH_RX_LOW;
                                endcase
                            end
                            n_shift   = '0;
                            n_bit_cnt = '0;
                        end
                        PH_MACK_LOW: begin
                            n_phase   = PH_RX_HIGH;
                            n_bit_cnt = '0;
                        end
                        PH_MACK_HIGH: begin
                            n_phase   = PH_RX_PEC;
                            n_bit_cnt = '0;
                        end
                        PH_MNACK_PEC: begin
                            n_phase = PH_STOP_END;
                        end
                        default: begin
                            // A PEC match at end stop passes, else retry or fail.
                            if ((r_phase == PH_STOP_END) && (r_crc == r_shift)) begin
                                n_phase  = PH_IDLE;
                                res_done = 1'b1;
                                res_word = {r_high, r_low};
                            end else if (retry_exhausted) begin
                                n_phase  = PH_IDLE;
                                res_done = 1'b1;
                                res_fail = 1'b1;
                            end else begin
                                n_att     = r_att + ATT_W'(1);
                                n_phase   = PH_START;
                                n_bit_cnt = '0;
                                n_qidx    = '0;
                                n_tick    = '0;
                                n_crc     = '0;
                                n_shift   = '0;
                            end
                            if (res_done) begin
                                res_scl  = 1'b1;
                                res_sda  = 1'b1;
                                res_busy = 1'b0;
                            end
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_bit_cnt <= '0;
            r_qidx    <= '0;
            r_tick    <= '0;
            r_shift   <= '0;
            r_crc     <= '0;
            r_att     <= '0;
            r_addr    <= '0;
            r_cmd     <= '0;
            r_low     <= '0;
            r_high    <= '0;
        end else if (in_accept) begin
            r_phase   <= n_phase;
            r_bit_cnt <= n_bit_cnt;
            r_qidx    <= n_qidx;
            r_tick    <= n_tick;
            r_shift   <= n_shift;
            r_crc     <= n_crc;
            r_att     <= n_att;
            r_addr    <= n_addr;
            r_cmd     <= n_cmd;
            r_low     <= n_low;
            r_high    <= n_high;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_scl  <= res_scl;
            r_sda  <= res_sda;
            r_busy <= res_busy;
            r_done <= res_done;
            r_word <= res_word;
            r_fail <= res_fail;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_scl_release = r_scl;
    assign o_sda_release = r_sda;
    assign o_busy_res    = r_busy;
    assign o_done_res    = r_done;
    assign o_read_word   = r_word;
    assign o_failed      = r_fail;

endmodule

// ===== rtl/smbus_rw_checker.sv =====
module smbus_rw_checker
    import smbus_rw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              o_stall,
    input  logic              o_valid,
    input  logic              i_stall,
    input  logic              o_scl_release,
    input  logic              o_sda_release,
    input  logic              o_busy_res,
    input  logic              o_done_res,
    input  logic [WORD_W-1:0] o_read_word,
    input  logic              o_failed
);

    // A result waiting under stall keeps every field.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_scl_release) &&
        $stable(o_sda_release) && $stable(o_busy_res) && $stable(o_done_res) &&
        $stable(o_read_word) && $stable(o_failed))
        else $error("stalled result changed");

    // The block only pushes back when it holds a result.
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall without a pending result");

    // The finishing tick releases both lines and drops busy.
    a_done_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res |-> !o_busy_res && o_scl_release && o_sda_release)
        else $error("done tick with busy or a driven line");

    a_fail_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_failed |-> o_done_res && (o_read_word == '0))
        else $error("failure outside a done tick or with data");

    a_word_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_read_word != '0) |-> o_done_res)
        else $error("read word outside a done tick");

endmodule

bind smbus_read_word_pec_master smbus_rw_checker u_smbus_rw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_scl_release (o_scl_release),
    .o_sda_release (o_sda_release),
    .o_busy_res    (o_busy_res),
    .o_done_res    (o_done_res),
    .o_read_word   (o_read_word),
    .o_failed      (o_failed)
);
